// File: hdl/prtb_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the positional random threshold pipeline.
package prtb_pkg;

    localparam int XY_W    = 32;
    localparam int Y_W     = 7;
    localparam int SEED_W  = 64;
    localparam int STATE_W = 48;
    localparam int HALF_W  = 24;
    localparam int VAL_W   = 24;

    // position hash
    localparam logic [21:0] HASH_XK = 22'h2fc20f;
    localparam logic [26:0] HASH_ZK = 27'h6ebfff5;

    // square mix
    localparam logic [25:0] MIX_SQ  = 26'h285b825;

    // 48-bit LCG: multiplier split into a 24-bit low half and an 11-bit high half
    localparam logic [47:0] LCG_MULT    = 48'h0005deece66d;
    localparam logic [23:0] LCG_MULT_LO = 24'hece66d;
    localparam logic [10:0] LCG_MULT_HI = 11'h5de;
    localparam logic [47:0] LCG_INC     = 48'hb;

    localparam logic [6:0]  BAND_TOP = 7'd127;

endpackage

// File: hdl/prtb_hash.sv
`timescale 1ns / 1ps
// Position hash and the partial products of its square (two stages).
module prtb_hash
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic signed [31:0]          x_pos,
    input  logic        [6:0]           y_layer,
    input  logic signed [31:0]          z_pos,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic        [63:0]          sq_lo,
    output logic        [30:0]          sq_cross,
    output logic        [63:0]          lin,
    output logic        [6:0]           y_out
);
    import prtb_pkg::*;

    logic               va_reg;
    logic               vb_reg;
    logic               ld_a;
    logic               ld_b;

    logic [31:0]        hx_reg;
    logic [63:0]        hz_reg;
    logic [6:0]         ya_reg;
    logic [63:0]        sq_reg;
    logic [30:0]        cross_reg;
    logic [63:0]        lin_reg;
    logic [6:0]         yb_reg;

    logic [53:0]        px_full;
    logic signed [59:0] pz_full;
    logic [63:0]        h;
    logic [63:0]        sq_next;
    logic [63:0]        cross_full;
    logic [63:0]        lin_next;

    assign ld_b     = !vb_reg || dn_ready;
    assign ld_a     = !va_reg || ld_b;
    assign up_ready = ld_a;

    // stage A: the two coordinate products
    assign px_full = $unsigned(x_pos) * HASH_XK;
    assign pz_full = z_pos * $signed({1'b0, HASH_ZK});

    // stage B: h = hx ^ hz ^ y, then low/cross products of h*h mod 2^64 and h*11
    assign h          = {{32{hx_reg[31]}}, hx_reg} ^ hz_reg ^ {57'd0, ya_reg};
    assign sq_next    = h[31:0] * h[31:0];
    assign cross_full = h[31:0] * h[63:32];
    assign lin_next   = (h << 3) + (h << 1) + h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ld_a)
            begin
                va_reg <= up_valid;
            end
            if (ld_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_a && up_valid)
        begin
            hx_reg <= px_full[31:0];
            hz_reg <= {{4{pz_full[59]}}, pz_full};
            ya_reg <= y_layer;
        end
        if (ld_b && va_reg)
        begin
            sq_reg    <= sq_next;
            cross_reg <= cross_full[30:0];
            lin_reg   <= lin_next;
            yb_reg    <= ya_reg;
        end
    end

    assign dn_valid = vb_reg;
    assign sq_lo    = sq_reg;
    assign sq_cross = cross_reg;
    assign lin      = lin_reg;
    assign y_out    = yb_reg;

endmodule

// File: hdl/prtb_mix.sv
`timescale 1ns / 1ps
// Square mix, seed XOR and generator scramble (three stages).
module prtb_mix
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic        [63:0]          sq_lo,
    input  logic        [30:0]          sq_cross,
    input  logic        [63:0]          lin,
    input  logic        [6:0]           y_in,
    input  logic signed [63:0]          seed,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic        [47:0]          state,
    output logic        [6:0]           y_out
);
    import prtb_pkg::*;

    logic         vc_reg;
    logic         vd_reg;
    logic         ve_reg;
    logic         ld_c;
    logic         ld_d;
    logic         ld_e;

    logic [63:0]  g_reg;
    logic [63:0]  linc_reg;
    logic [6:0]   yc_reg;
    logic [57:0]  pl_reg;
    logic [31:0]  ph_reg;
    logic [63:0]  lind_reg;
    logic [6:0]   yd_reg;
    logic [47:0]  s_reg;
    logic [6:0]   ye_reg;

    logic [63:0]  g_next;
    logic [57:0]  pl_next;
    logic [57:0]  ph_full;
    logic [63:0]  e_sum;
    logic [47:0]  s_next;

    assign ld_e     = !ve_reg || dn_ready;
    assign ld_d     = !vd_reg || ld_e;
    assign ld_c     = !vc_reg || ld_d;
    assign up_ready = ld_c;

    // h*h mod 2^64 = lo + cross * 2^33
    assign g_next  = sq_lo + {sq_cross, 33'd0};
    // g*MIX_SQ mod 2^64 from two halves
    assign pl_next = g_reg[31:0] * MIX_SQ;
    assign ph_full = g_reg[63:32] * MIX_SQ;
    assign e_sum   = {ph_reg, 32'd0} + {6'd0, pl_reg} + lind_reg;
    assign s_next  = e_sum[63:16] ^ seed[47:0] ^ LCG_MULT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            if (ld_c)
            begin
                vc_reg <= up_valid;
            end
            if (ld_d)
            begin
                vd_reg <= vc_reg;
            end
            if (ld_e)
            begin
                ve_reg <= vd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_c && up_valid)
        begin
            g_reg    <= g_next;
            linc_reg <= lin;
            yc_reg   <= y_in;
        end
        if (ld_d && vc_reg)
        begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_full[31:0];
            lind_reg <= linc_reg;
            yd_reg   <= yc_reg;
        end
        if (ld_e && vd_reg)
        begin
            s_reg  <= s_next;
            ye_reg <= yd_reg;
        end
    end

    assign dn_valid = ve_reg;
    assign state    = s_reg;
    assign y_out    = ye_reg;

endmodule

// File: hdl/prtb_step.sv
`timescale 1ns / 1ps
// One generator step and the layer threshold compare (two stages, output register).
module prtb_step
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  logic [47:0]     state,
    input  logic [6:0]      y_in,
    output logic            dn_valid,
    input  logic            dn_stall,
    output logic            solid,
    output logic [23:0]     random_value
);
    import prtb_pkg::*;

    logic           vf_reg;
    logic           vg_reg;
    logic           ld_f;
    logic           ld_g;

    logic [47:0]    pll_reg;
    logic [23:0]    plh_reg;
    logic [23:0]    phl_reg;
    logic [6:0]     yf_reg;
    logic           solid_reg;
    logic [23:0]    value_reg;

    logic [47:0]    pll_next;
    logic [34:0]    plh_full;
    logic [47:0]    phl_full;
    logic [23:0]    mid;
    logic [47:0]    s_next;
    logic [23:0]    v;
    logic [30:0]    lhs;
    logic [30:0]    rhs;

    assign ld_g     = !vg_reg || !dn_stall;
    assign ld_f     = !vf_reg || ld_g;
    assign up_ready = ld_f;

    // s*M mod 2^48 = sl*Ml + ((sl*Mh + sh*Ml) mod 2^24) << 24
    assign pll_next = state[23:0] * LCG_MULT_LO;
    assign plh_full = state[23:0] * LCG_MULT_HI;
    assign phl_full = state[47:24] * LCG_MULT_LO;

    assign mid    = plh_reg + phl_reg;
    assign s_next = pll_reg + {mid, 24'd0} + LCG_INC;
    assign v      = s_next[47:24];
    assign lhs    = {5'd0, v, 2'd0} + {7'd0, v};
    assign rhs    = {BAND_TOP - yf_reg, 24'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else
        begin
            if (ld_f)
            begin
                vf_reg <= up_valid;
            end
            if (ld_g)
            begin
                vg_reg <= vf_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_f && up_valid)
        begin
            pll_reg <= pll_next;
            plh_reg <= plh_full[23:0];
            phl_reg <= phl_full[23:0];
            yf_reg  <= y_in;
        end
        if (ld_g && vf_reg)
        begin
            solid_reg <= (lhs >= rhs);
            value_reg <= v;
        end
    end

    assign dn_valid     = vg_reg;
    assign solid        = solid_reg;
    assign random_value = value_reg;

endmodule

// File: hdl/positional_random_threshold_bit.sv
`timescale 1ns / 1ps
// Top level: positional hash, 48-bit generator step and layer threshold bit.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  input    | in_valid / in_stall  | x_pos, y_layer, z_pos
//  output   | out_valid / out_stall| solid, random_value
//  config   | position_seed_wr_en  | position_seed
//
// Seven register stages, the last one being the output register; one transfer
// per cycle sustained while out_stall is low.
// Stage count is set by the split 64-bit multiplies of the hash square mix.
// Reset clears all stage valid bits and the seed to zero.
// Each stage loads when it is empty or the stage after it loads, so bubbles
// close up under out_stall and nothing is dropped or repeated.
module positional_random_threshold_bit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  x_pos,
    input  logic        [6:0]   y_layer,
    input  logic signed [31:0]  z_pos,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                solid,
    output logic        [23:0]  random_value,
    input  logic                position_seed_wr_en,
    input  logic signed [63:0]  position_seed
);
    import prtb_pkg::*;

    logic signed [63:0] seed_reg;

    logic               hash_ready;
    logic               hash_valid;
    logic [63:0]        sq_lo;
    logic [30:0]        sq_cross;
    logic [63:0]        lin;
    logic [6:0]         y_hash;

    logic               mix_ready;
    logic               mix_valid;
    logic [47:0]        state;
    logic [6:0]         y_mix;

    logic               step_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (position_seed_wr_en)
        begin
            seed_reg <= position_seed;
        end
    end

    assign in_stall = !hash_ready;

    prtb_hash u_hash
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (hash_ready),
        .x_pos    (x_pos),
        .y_layer  (y_layer),
        .z_pos    (z_pos),
        .dn_valid (hash_valid),
        .dn_ready (mix_ready),
        .sq_lo    (sq_lo),
        .sq_cross (sq_cross),
        .lin      (lin),
        .y_out    (y_hash)
    );

    prtb_mix u_mix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (hash_valid),
        .up_ready (mix_ready),
        .sq_lo    (sq_lo),
        .sq_cross (sq_cross),
        .lin      (lin),
        .y_in     (y_hash),
        .seed     (seed_reg),
        .dn_valid (mix_valid),
        .dn_ready (step_ready),
        .state    (state),
        .y_out    (y_mix)
    );

    prtb_step u_step
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (mix_valid),
        .up_ready     (step_ready),
        .state        (state),
        .y_in         (y_mix),
        .dn_valid     (out_valid),
        .dn_stall     (out_stall),
        .solid        (solid),
        .random_value (random_value)
    );

endmodule
